@@ hw/rtl/tpls_pkg.sv @@
// Shared constants, types and helpers for the template point lane scorer.
package tpls_pkg;

    localparam int LANES        = 32;
    localparam int NARROW_LANES = 16;
    localparam int NARROW_ACTIVE = (LANES < NARROW_LANES) ? LANES : NARROW_LANES;
    localparam int BYTE_W       = 8;
    localparam int SUM_W        = 32;
    localparam int PROD_W       = 2 * BYTE_W;
    localparam int LANE_W       = 5;
    localparam int CNT_W        = $clog2(LANES + 1);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_THRESHOLD = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_WIDE_MODE = t_cfg_idx'(1);

    typedef logic [LANES-1:0][SUM_W-1:0]  t_sum_arr;
    typedef logic [LANES-1:0][PROD_W-1:0] t_prod_arr;

    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

    // Number of lanes scored in the selected mode.
    function automatic logic [CNT_W-1:0] active_lanes(input logic wide);
        return wide ? CNT_W'(LANES) : CNT_W'(NARROW_ACTIVE);
    endfunction

endpackage

@@ hw/rtl/tpls_lane_mul.sv @@
// Input register and per-lane byte times weight product stage.
module tpls_lane_mul
    import tpls_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  logic [LANES*BYTE_W-1:0] i_bytes,
    input  logic [BYTE_W-1:0]       i_weight,
    input  logic                    i_last,
    input  logic                    i_wide,
    input  logic                    i_s2_pull,
    output logic                    o_s1_free,
    output t_stage_ctl              o_s2_ctl,
    output t_prod_arr               o_prod
);

    t_stage_ctl                r_s1_ctl;
    logic [LANES*BYTE_W-1:0]   r_s1_bytes;
    logic [BYTE_W-1:0]         r_s1_weight;
    t_stage_ctl                r_s2_ctl;
    t_prod_arr                 r_s2_prod;
    t_prod_arr                 n_prod;
    logic                      s2_load_ok;
    logic                      s1_move;
    logic [CNT_W-1:0]          act_cnt;

    assign s2_load_ok = !r_s2_ctl.valid || i_s2_pull;
    assign s1_move    = r_s1_ctl.valid && s2_load_ok;
    assign o_s1_free  = !r_s1_ctl.valid || s1_move;
    assign act_cnt    = active_lanes(i_wide);

    // Inactive lanes contribute nothing.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (CNT_W'(k) < act_cnt) begin
                n_prod[k] = PROD_W'(r_s1_bytes[k*BYTE_W +: BYTE_W]) * PROD_W'(r_s1_weight);
            end else begin
                n_prod[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
        end else begin
            if (o_s1_free) begin
                r_s1_ctl.valid <= i_take;
                r_s1_ctl.last  <= i_last;
            end
            if (s2_load_ok) begin
                r_s2_ctl.valid <= s1_move;
                r_s2_ctl.last  <= r_s1_ctl.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && o_s1_free) begin
            r_s1_bytes  <= i_bytes;
            r_s1_weight <= i_weight;
        end
        if (s1_move) begin
            r_s2_prod <= n_prod;
        end
    end

    assign o_s2_ctl = r_s2_ctl;
    assign o_prod   = r_s2_prod;

endmodule

@@ hw/rtl/tpls_lane_acc.sv @@
// Per-lane 32-bit running sums, cleared after the last point of a block.
module tpls_lane_acc
    import tpls_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stage_ctl i_s2_ctl,
    input  t_prod_arr  i_prod,
    input  logic       i_buf_free,
    output logic       o_pull,
    output logic       o_load,
    output t_sum_arr   o_load_sums
);

    t_sum_arr r_sums;
    t_sum_arr n_total;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_total[k] = r_sums[k] + SUM_W'(i_prod[k]);
        end
    end

    // Hold a last point until the result buffer can take the totals.
    assign o_pull      = i_s2_ctl.valid && (!i_s2_ctl.last || i_buf_free);
    assign o_load      = o_pull && i_s2_ctl.last;
    assign o_load_sums = n_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums <= '0;
        end else if (o_pull) begin
            r_sums <= i_s2_ctl.last ? '0 : n_total;
        end
    end

endmodule

@@ hw/rtl/tpls_emit.sv @@
// Result buffer, pass mask and output register: one lane result per item.
module tpls_emit
    import tpls_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_sum_arr          i_load_sums,
    input  logic              i_wide,
    input  logic [SUM_W-1:0]  i_thr,
    input  logic              i_out_stall,
    output logic              o_free,
    output logic              o_out_valid,
    output logic [LANE_W-1:0] o_lane_index,
    output logic [SUM_W-1:0]  o_raw_cost,
    output logic              o_lane_valid,
    output logic [LANES-1:0]  o_valid_mask,
    output logic              o_last_lane
);

    localparam logic [1:0] PH_EMPTY = 2'd0;
    localparam logic [1:0] PH_MASK  = 2'd1;
    localparam logic [1:0] PH_EMIT  = 2'd2;

    logic [1:0]         r_phase;
    t_sum_arr           r_buf;
    t_sum_arr           n_shift;
    logic [CNT_W-1:0]   r_cnt;
    logic [LANE_W-1:0]  r_idx;
    logic [LANES-1:0]   r_mask;
    logic [LANES-1:0]   n_mask;
    logic               r_out_valid;
    logic [LANE_W-1:0]  r_out_idx;
    logic [SUM_W-1:0]   r_out_cost;
    logic               r_out_pass;
    logic [LANES-1:0]   r_out_mask;
    logic               r_out_last;
    logic               out_take;
    logic               final_take;

    assign out_take   = (r_phase == PH_EMIT) && (!r_out_valid || !i_out_stall);
    assign final_take = out_take && (r_cnt == CNT_W'(1));
    assign o_free     = (r_phase == PH_EMPTY) || final_take;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_mask[k] = (CNT_W'(k) < r_cnt) && (r_buf[k] <= i_thr);
        end
        for (int k = 0; k < LANES - 1; k++) begin
            n_shift[k] = r_buf[k+1];
        end
        n_shift[LANES-1] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_EMPTY;
            r_out_valid <= 1'b0;
        end else begin
            if (out_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_load) begin
                r_phase <= PH_MASK;
            end else begin
                unique case (r_phase)
                    PH_EMPTY: r_phase <= PH_EMPTY;
                    PH_MASK:  r_phase <= PH_EMIT;
                    PH_EMIT: begin
                        if (final_take) begin
                            r_phase <= PH_EMPTY;
                        end
                    end
                    default:  r_phase <= PH_EMPTY;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out_idx  <= r_idx;
            r_out_cost <= r_buf[0];
            r_out_pass <= (r_buf[0] <= i_thr);
            r_out_mask <= r_mask;
            r_out_last <= (r_cnt == CNT_W'(1));
        end
        if (i_load) begin
            r_buf <= i_load_sums;
            r_cnt <= active_lanes(i_wide);
            r_idx <= '0;
        end else if (r_phase == PH_MASK) begin
            r_mask <= n_mask;
        end else if (out_take) begin
            // Advance to the next lane: shift the buffer down.
            r_buf <= n_shift;
            r_cnt <= r_cnt - CNT_W'(1);
            r_idx <= r_idx + LANE_W'(1);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_lane_index = r_out_idx;
    assign o_raw_cost   = r_out_cost;
    assign o_lane_valid = r_out_pass;
    assign o_valid_mask = r_out_mask;
    assign o_last_lane  = r_out_last;

`ifndef SYNTH
    a_emit_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EMIT) |-> (r_cnt != '0))
        else $error("emit phase with no lanes left");

    a_mask_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MASK) |=> (r_phase == PH_EMIT))
        else $error("mask phase did not move to emission");

    a_final_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        final_take |=> (r_out_valid && r_out_last))
        else $error("final lane result not flagged last");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result buffer loaded while still busy");
`endif

endmodule

@@ hw/rtl/template_point_lane_score.sv @@
// Top level of the template point lane scorer: config registers and stage wiring.
//
// Input channel (i_in_valid / o_in_stall): one template point per item, with
// 32 cost bytes (one per lane), a weight and a last flag. An item is taken at
// each edge where i_in_valid is high and o_in_stall is low; one item per cycle
// is sustained while points stream in and o_in_stall stays low.
// Output channel (o_out_valid / i_out_stall): on a last point, one result per
// active lane (32 in wide mode, 16 in narrow mode) in lane order, one per cycle
// while the receiver does not stall; the final one carries o_last_lane.
// A last point passes the input and product registers and loads the result
// buffer; after the pass mask step, lane results reach the output register.
// A block of n lanes holds the buffer for the mask step, then one lane per cycle
// when not stalled; a following last point waits in the pipeline until
// the buffer drains, so points flow on if each block has at least n + 1 points.
// Receiver stall holds the output register and the buffer; a last point then
// waits in the product stage; once the input register fills, o_in_stall rises.
// Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 threshold,
// index 1 wide mode; write only while no item is in flight.
// Reset: synchronous, active low; clears sums, pipeline, threshold to zero and
// selects wide mode.
module template_point_lane_score
    import tpls_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [63:0]           i_cost_bytes_a,
    input  logic [63:0]           i_cost_bytes_b,
    input  logic [63:0]           i_cost_bytes_c,
    input  logic [63:0]           i_cost_bytes_d,
    input  logic [7:0]            i_point_weight,
    input  logic                  i_last_point,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [LANE_W-1:0]     o_lane_index,
    output logic [SUM_W-1:0]      o_raw_cost,
    output logic                  o_lane_valid,
    output logic [LANES-1:0]      o_valid_mask,
    output logic                  o_last_lane,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SUM_W-1:0]   r_thr;
    logic               r_wide;
    logic [255:0]       all_bytes;
    logic               in_take;
    logic               s1_free;
    t_stage_ctl         s2_ctl;
    t_prod_arr          prod;
    logic               s2_pull;
    logic               buf_load;
    t_sum_arr           load_sums;
    logic               buf_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= '0;
            r_wide <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_thr  <= i_cfg_data[SUM_W-1:0];
                CFG_WIDE_MODE: r_wide <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign all_bytes  = {i_cost_bytes_d, i_cost_bytes_c, i_cost_bytes_b, i_cost_bytes_a};
    assign o_in_stall = !s1_free;
    assign in_take    = i_in_valid && s1_free;

    tpls_lane_mul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (in_take),
        .i_bytes    (all_bytes[LANES*BYTE_W-1:0]),
        .i_weight   (i_point_weight),
        .i_last     (i_last_point),
        .i_wide     (r_wide),
        .i_s2_pull  (s2_pull),
        .o_s1_free  (s1_free),
        .o_s2_ctl   (s2_ctl),
        .o_prod     (prod)
    );

    tpls_lane_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s2_ctl    (s2_ctl),
        .i_prod      (prod),
        .i_buf_free  (buf_free),
        .o_pull      (s2_pull),
        .o_load      (buf_load),
        .o_load_sums (load_sums)
    );

    tpls_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (buf_load),
        .i_load_sums  (load_sums),
        .i_wide       (r_wide),
        .i_thr        (r_thr),
        .i_out_stall  (i_out_stall),
        .o_free       (buf_free),
        .o_out_valid  (o_out_valid),
        .o_lane_index (o_lane_index),
        .o_raw_cost   (o_raw_cost),
        .o_lane_valid (o_lane_valid),
        .o_valid_mask (o_valid_mask),
        .o_last_lane  (o_last_lane)
    );

endmodule

@@ sim/tpls_score_checker.sv @@
// Scoreboard for the template point lane scorer: tracks lane sums and checks every lane result.
module tpls_score_checker
    import tpls_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [63:0]           i_cost_bytes_a,
    input  logic [63:0]           i_cost_bytes_b,
    input  logic [63:0]           i_cost_bytes_c,
    input  logic [63:0]           i_cost_bytes_d,
    input  logic [7:0]            i_point_weight,
    input  logic                  i_last_point,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [LANE_W-1:0]     i_lane_index,
    input  logic [SUM_W-1:0]      i_raw_cost,
    input  logic                  i_lane_valid,
    input  logic [LANES-1:0]      i_valid_mask,
    input  logic                  i_last_lane,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_compared
);

    typedef struct packed {
        logic [LANE_W-1:0] lane;
        logic [SUM_W-1:0]  cost;
        logic              pass;
        logic [LANES-1:0]  mask;
        logic              final_lane;
    } t_lane_result;

    logic [SUM_W-1:0] lane_sum [LANES];
    logic [SUM_W-1:0] threshold;
    logic             wide;
    t_lane_result     lane_result_q[$];

    task automatic accumulate_point(input logic [4*64-1:0] cost_bytes,
                                    input logic [7:0] weight, input logic is_last);
        int               n;
        int               k;
        logic [PROD_W-1:0] prod;
        logic [LANES-1:0]  mask;
        t_lane_result      r;
        n    = wide ? LANES : NARROW_ACTIVE;
        mask = '0;
        // Inactive lanes keep whatever they hold until the block ends.
        for (k = 0; k < n; k++) begin
            prod        = cost_bytes[k*8 +: 8] * weight;
            lane_sum[k] = lane_sum[k] + SUM_W'(prod);
        end
        if (!is_last)
            return;
        for (k = 0; k < n; k++)
            if (lane_sum[k] <= threshold)
                mask[k] = 1'b1;
        for (k = 0; k < n; k++) begin
            r.lane       = LANE_W'(k);
            r.cost       = lane_sum[k];
            r.pass       = lane_sum[k] <= threshold;
            r.mask       = mask;
            r.final_lane = (k == n - 1);
            lane_result_q.push_back(r);
        end
        // Clear every lane, skipped ones included.
        for (k = 0; k < LANES; k++)
            lane_sum[k] = '0;
    endtask

    task automatic flag_mismatch(input string field, input int lane,
                                 input logic [31:0] expected_val, input logic [31:0] actual_val);
        $error("lane %0d %s: expected 0x%0h, actual 0x%0h", lane, field, expected_val, actual_val);
        o_fail_count++;
    endtask

    task automatic compare_result();
        t_lane_result e;
        if (lane_result_q.size() == 0) begin
            $error("lane result for lane %0d with none outstanding", i_lane_index);
            o_fail_count++;
            return;
        end
        e = lane_result_q.pop_front();
        o_compared++;
        if (i_lane_index !== e.lane)
            flag_mismatch("lane_index", int'(e.lane), 32'(e.lane), 32'(i_lane_index));
        if (i_raw_cost !== e.cost)
            flag_mismatch("raw_cost", int'(e.lane), e.cost, i_raw_cost);
        if (i_lane_valid !== e.pass)
            flag_mismatch("lane_valid", int'(e.lane), 32'(e.pass), 32'(i_lane_valid));
        if (i_valid_mask !== e.mask)
            flag_mismatch("valid_mask", int'(e.lane), e.mask, i_valid_mask);
        if (i_last_lane !== e.final_lane)
            flag_mismatch("last_lane", int'(e.lane), 32'(e.final_lane), 32'(i_last_lane));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            threshold = '0;
            wide      = 1'b1;
            for (int k = 0; k < LANES; k++)
                lane_sum[k] = '0;
            lane_result_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: threshold = i_cfg_data;
                    CFG_WIDE_MODE: wide = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                accumulate_point({i_cost_bytes_d, i_cost_bytes_c, i_cost_bytes_b, i_cost_bytes_a},
                                 i_point_weight, i_last_point);
            if (i_out_valid && !i_out_stall)
                compare_result();
        end
        o_pending = lane_result_q.size();
    end

endmodule

@@ sim/tb.sv @@
// Testbench top for the template point lane scorer: clock, reset, stimulus and verdict.
module tb;
    import tpls_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD     = 300;
    localparam int PHASES        = 6;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic [63:0]           i_cost_bytes_a = '0;
    logic [63:0]           i_cost_bytes_b = '0;
    logic [63:0]           i_cost_bytes_c = '0;
    logic [63:0]           i_cost_bytes_d = '0;
    logic [7:0]            i_point_weight = '0;
    logic                  i_last_point   = 1'b0;
    logic                  i_out_stall    = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    t_cfg_idx              i_cfg_index    = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [LANE_W-1:0]     o_lane_index;
    logic [SUM_W-1:0]      o_raw_cost;
    logic                  o_lane_valid;
    logic [LANES-1:0]      o_valid_mask;
    logic                  o_last_lane;
    logic                  o_cfg_ready;

    int fail_count;
    int pending;
    int compared;
    int quiet_cycles  = 0;
    int points_sent   = 0;
    int blocks_sent   = 0;
    int narrow_blocks = 0;
    int burst_left    = 0;
    bit steady        = 1'b0;
    bit hold_off_req  = 1'b0;
    bit mode_wide     = 1'b1;

    always #1 i_clk = ~i_clk;

    template_point_lane_score dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cost_bytes_a (i_cost_bytes_a),
        .i_cost_bytes_b (i_cost_bytes_b),
        .i_cost_bytes_c (i_cost_bytes_c),
        .i_cost_bytes_d (i_cost_bytes_d),
        .i_point_weight (i_point_weight),
        .i_last_point   (i_last_point),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_lane_index   (o_lane_index),
        .o_raw_cost     (o_raw_cost),
        .o_lane_valid   (o_lane_valid),
        .o_valid_mask   (o_valid_mask),
        .o_last_lane    (o_last_lane),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    tpls_score_checker score_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_cost_bytes_a (i_cost_bytes_a),
        .i_cost_bytes_b (i_cost_bytes_b),
        .i_cost_bytes_c (i_cost_bytes_c),
        .i_cost_bytes_d (i_cost_bytes_d),
        .i_point_weight (i_point_weight),
        .i_last_point   (i_last_point),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_lane_index   (o_lane_index),
        .i_raw_cost     (o_raw_cost),
        .i_lane_valid   (o_lane_valid),
        .i_valid_mask   (o_valid_mask),
        .i_last_lane    (o_last_lane),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_compared     (compared)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $error("no handshake for %0d cycles, %0d lane results outstanding",
                   QUIET_LIMIT, pending);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: stretches of random stall density, and one long hold-off on request.
    initial begin : receiver
        int run_len;
        int stall_pct;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                repeat (LONG_HOLD) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                run_len = $urandom_range(1, 40);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 30;
                    3:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                repeat (run_len) begin
                    @(posedge i_clk);
                    i_out_stall <= ($urandom_range(0, 99) < stall_pct);
                end
            end
        end
    end

    task automatic send_point(input logic [63:0] a, input logic [63:0] b, input logic [63:0] c,
                              input logic [63:0] d, input logic [7:0] weight,
                              input logic is_last);
        int gap;
        if (!steady && burst_left <= 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_cost_bytes_a <= a;
        i_cost_bytes_b <= b;
        i_cost_bytes_c <= c;
        i_cost_bytes_d <= d;
        i_point_weight <= weight;
        i_last_point   <= is_last;
        do @(posedge i_clk); while (o_in_stall);
        points_sent++;
        if (is_last) begin
            blocks_sent++;
            if (!mode_wide)
                narrow_blocks++;
        end
    endtask

    // Drop valid and wait until every lane result is in and the pipeline is empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_WIDE_MODE)
            mode_wide = data[0];
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] random_bytes();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [7:0] random_weight();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_block(input int points);
        for (int p = 1; p <= points; p++)
            send_point(random_bytes(), random_bytes(), random_bytes(), random_bytes(),
                       random_weight(), p == points);
    endtask

    initial begin : stimulus
        int phase_points;
        int len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset config: wide, threshold zero.
        send_point('1, '1, '1, '1, 8'hFF, 1'b1);
        send_point('0, '0, '0, '0, 8'h00, 1'b1);
        send_point(64'h0706050403020100, 64'h0F0E0D0C0B0A0908,
                   64'h1716151413121110, 64'h1F1E1D1C1B1A1918, 8'd1, 1'b0);
        send_point('1, '1, '1, '1, 8'd0, 1'b0);
        send_point(64'h0706050403020100, 64'h0F0E0D0C0B0A0908,
                   64'h1716151413121110, 64'h1F1E1D1C1B1A1918, 8'hFF, 1'b1);
        settle();
        cfg_write(CFG_THRESHOLD, '1);
        repeat (2) send_point('1, '1, '1, '1, 8'hFF, 1'b0);
        send_point('1, '1, '1, '1, 8'hFF, 1'b1);
        settle();

        // Even lanes land exactly on the threshold, odd lanes one above it.
        cfg_write(CFG_THRESHOLD, 32'd65025);
        send_point('1, '1, '1, '1, 8'hFF, 1'b0);
        send_point(64'h0100010001000100, 64'h0100010001000100,
                   64'h0100010001000100, 64'h0100010001000100, 8'd1, 1'b1);
        settle();

        cfg_write(CFG_WIDE_MODE, 32'd0);
        send_point(random_bytes(), random_bytes(), '1, '1, random_weight(), 1'b0);
        send_point(random_bytes(), random_bytes(), '1, '1, random_weight(), 1'b1);
        settle();

        // Narrow to wide inside a block: upper lanes see only the last point.
        cfg_write(CFG_THRESHOLD, 32'd1000);
        repeat (2) send_point('1, '1, '1, '1, 8'hFF, 1'b0);
        settle();
        cfg_write(CFG_WIDE_MODE, 32'd1);
        send_point('1, '1, '1, '1, 8'd1, 1'b1);
        settle();

        // Wide to narrow inside a block: upper partial sums must be cleared at block end.
        repeat (2) send_point('1, '1, '1, '1, 8'hFF, 1'b0);
        settle();
        cfg_write(CFG_WIDE_MODE, 32'd0);
        send_point('0, '0, '0, '0, 8'd0, 1'b1);
        settle();
        cfg_write(CFG_WIDE_MODE, 32'd1);
        send_point('0, '0, '0, '0, 8'd0, 1'b1);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            cfg_write(CFG_WIDE_MODE, (phase == 0) ? 32'd0 : 32'($urandom_range(0, 1)));
            case (phase % 4)
                0:       cfg_write(CFG_THRESHOLD, '0);
                1:       cfg_write(CFG_THRESHOLD, '1);
                2:       cfg_write(CFG_THRESHOLD, $urandom);
                default: cfg_write(CFG_THRESHOLD, 32'($urandom_range(20000, 400000)));
            endcase
            steady = (phase == 3);
            phase_points = 0;
            while (phase_points < 24) begin
                len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 10);
                send_random_block(len);
                phase_points += len;
            end
            steady = 1'b0;
            settle();

            // Send blocks of two points while the receiver holds off.
            if (phase == 4) begin
                cfg_write(CFG_WIDE_MODE, 32'd1);
                cfg_write(CFG_THRESHOLD, 32'($urandom_range(20000, 100000)));
                hold_off_req = 1'b1;
                steady = 1'b1;
                repeat (20) send_random_block(2);
                steady = 1'b0;
                settle();
            end
        end

        settle();
        $display("tb: scored %0d template points in %0d blocks (%0d in 16-lane mode)",
                 points_sent, blocks_sent, narrow_blocks);
        $display("tb: compared %0d lane results, incl. threshold edges and mode switches",
                 compared);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
